// ===== rtl/efts_pkg.sv =====
// Shared constants for the edge-function triangle scanner.
`timescale 1ns / 1ps

package efts_pkg;

  // Default coordinate width of vertices and pixels.
  localparam int CoordBitsDef = 12;

  // Configuration register map.
  localparam int NumCfgRegs = 6;
  localparam int CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] CfgAX = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgAY = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgBX = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgBY = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgCX = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgCY = 3'd5;

  // Depth of the queue between the scan front and the edge test back.
  localparam int QueueDepth = 2;
  localparam int QueueCntBits = 2;

endpackage

// ===== rtl/efts_if.sv =====
// Stream interfaces for the scan request items and the pixel result items.
`timescale 1ns / 1ps

interface efts_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface efts_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  inside_res;
  logic                  last_point;

  modport source (output valid, output pixel_x, output pixel_y, output inside_res,
                  output last_point, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input inside_res,
                input last_point, output ready);
endinterface

// ===== rtl/edge_function_triangle_scan.sv =====
// Top level of the edge-function triangle scanner.
//
// The three triangle vertices are written through the configuration port
// (index 0..5: a.x, a.y, b.x, b.y, c.x, c.y); other indexes are ignored.
// Each item on item_in visits the next point of the triangle's bounding box,
// x outer and y inner; restart=1, or the item after the last box point,
// begins a new scan at the box corner and latches box and orientation.
// Each item gives one item on pix_out: the point, whether it lies strictly
// inside the triangle, and a flag on the final box point.
// A result passes through the queue, the product stage and the output register.
// Throughput: one item per cycle while pix_out does not stall, set by the scan
// front and the two-stage product and sign pipeline behind it.
// A two-entry queue sits between front and back; when pix_out stalls, the
// queue and the back stages fill and item_in.ready falls after four items.
// Reset clears the scan state, the vertices to zero and all pending items.
`timescale 1ns / 1ps

module edge_function_triangle_scan #(
  parameter int COORD_BITS = efts_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [efts_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]           cfg_data_i,
  efts_in_if.sink                         item_in,
  efts_out_if.source                      pix_out
);
  import efts_pkg::*;

  localparam int QW = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0]   ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic                    accept, q_full, q_pop, q_valid;
  logic [QW-1:0]           front_item, q_head;
  logic [QueueCntBits-1:0] q_count;
  logic                    a_valid, a_en;

  // Vertex registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAX:   ax_q <= cfg_data_i;
        CfgAY:   ay_q <= cfg_data_i;
        CfgBX:   bx_q <= cfg_data_i;
        CfgBY:   by_q <= cfg_data_i;
        CfgCX:   cx_q <= cfg_data_i;
        CfgCY:   cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item_in.ready = !q_full;
  assign accept        = item_in.valid && !q_full;

  efts_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .restart_i(item_in.restart),
    .ax_i     (ax_q),
    .ay_i     (ay_q),
    .bx_i     (bx_q),
    .by_i     (by_q),
    .cx_i     (cx_q),
    .cy_i     (cy_q),
    .item_o   (front_item)
  );

  efts_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_head),
    .count_o(q_count)
  );

  efts_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ax_i         (ax_q),
    .ay_i         (ay_q),
    .bx_i         (bx_q),
    .by_i         (by_q),
    .cx_i         (cx_q),
    .cy_i         (cy_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .stage_valid_o(a_valid),
    .stage_en_o   (a_en),
    .pix_out      (pix_out)
  );

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QueueCntBits'(QueueDepth))
    else $error("scan queue count beyond its depth");

  // An accepted item is in the queue in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (q_count != '0))
    else $error("accepted item missing from the scan queue");

  // A product stage that cannot move keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid && !a_en) |=> a_valid)
    else $error("stalled product stage lost its item");

endmodule

// ===== rtl/efts_front.sv =====
// Scan front: walks the bounding box one point per accepted item.
`timescale 1ns / 1ps

module efts_front #(
  parameter int COORD_BITS = efts_pkg::CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    restart_i,
  input  logic [COORD_BITS-1:0]   ax_i,
  input  logic [COORD_BITS-1:0]   ay_i,
  input  logic [COORD_BITS-1:0]   bx_i,
  input  logic [COORD_BITS-1:0]   by_i,
  input  logic [COORD_BITS-1:0]   cx_i,
  input  logic [COORD_BITS-1:0]   cy_i,
  output logic [2*COORD_BITS+1:0] item_o
);
  import efts_pkg::*;

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] col_q, col_d, row_q, row_d;
  logic signed [CB-1:0] xmin_q, xmin_d, ymin_q, ymin_d;
  logic signed [CB-1:0] xmax_q, xmax_d, ymax_q, ymax_d;
  logic                 active_q, active_d;
  logic                 start;
  logic                 last;

  function automatic logic signed [CB-1:0] min3(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b,
                                                logic signed [CB-1:0] c);
    logic signed [CB-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CB-1:0] max3(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b,
                                                logic signed [CB-1:0] c);
    logic signed [CB-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Next scan point: a new scan latches the box, otherwise y steps inner, x outer.
  always_comb begin
    start  = restart_i || !active_q;
    xmin_d = xmin_q;
    ymin_d = ymin_q;
    xmax_d = xmax_q;
    ymax_d = ymax_q;
    col_d  = col_q;
    row_d  = row_q;
    if (start) begin
      xmin_d = min3($signed(ax_i), $signed(bx_i), $signed(cx_i));
      ymin_d = min3($signed(ay_i), $signed(by_i), $signed(cy_i));
      xmax_d = max3($signed(ax_i), $signed(bx_i), $signed(cx_i));
      ymax_d = max3($signed(ay_i), $signed(by_i), $signed(cy_i));
      col_d  = xmin_d;
      row_d  = ymin_d;
    end else if (row_q < ymax_q) begin
      row_d = row_q + CB'(1);
    end else begin
      row_d = ymin_q;
      if (col_q < xmax_q) begin
        col_d = col_q + CB'(1);
      end
    end
    last     = (col_d >= xmax_d) && (row_d >= ymax_d);
    active_d = !last;
  end

  // Scan state advances only when an item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      xmin_q   <= '0;
      ymin_q   <= '0;
      xmax_q   <= '0;
      ymax_q   <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      col_q    <= col_d;
      row_q    <= row_d;
      xmin_q   <= xmin_d;
      ymin_q   <= ymin_d;
      xmax_q   <= xmax_d;
      ymax_q   <= ymax_d;
      active_q <= active_d;
    end
  end

  // Queue entry: start flag, last flag, y, x.
  assign item_o = {start, last, row_d, col_d};

endmodule

// ===== rtl/efts_queue.sv =====
// Short queue of scan points between the front and the edge test back.
`timescale 1ns / 1ps

module efts_queue #(
  parameter int WIDTH = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [WIDTH-1:0]                 data_i,
  output logic                             full_o,
  input  logic                             pop_i,
  output logic                             valid_o,
  output logic [WIDTH-1:0]                 data_o,
  output logic [efts_pkg::QueueCntBits-1:0] count_o
);
  import efts_pkg::*;

  logic [QueueDepth-1:0][WIDTH-1:0] mem_q;
  logic                             wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0]          cnt_q;

  assign full_o  = (cnt_q == QueueCntBits'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QueueCntBits'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntBits'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/efts_back.sv =====
// Edge test back: edge-function products, sign test and the output register.
`timescale 1ns / 1ps

module efts_back #(
  parameter int COORD_BITS = efts_pkg::CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [COORD_BITS-1:0]   ax_i,
  input  logic [COORD_BITS-1:0]   ay_i,
  input  logic [COORD_BITS-1:0]   bx_i,
  input  logic [COORD_BITS-1:0]   by_i,
  input  logic [COORD_BITS-1:0]   cx_i,
  input  logic [COORD_BITS-1:0]   cy_i,
  input  logic                    head_valid_i,
  input  logic [2*COORD_BITS+1:0] head_i,
  output logic                    pop_o,
  output logic                    stage_valid_o,
  output logic                    stage_en_o,
  efts_out_if.source              pix_out
);
  import efts_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;

  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, px, py;
  logic                 h_start, h_last;

  logic signed [DW-1:0] d_ab_x, d_ab_y, d_bc_x, d_bc_y, d_ca_x, d_ca_y;
  logic signed [DW-1:0] d_pb_x, d_pb_y, d_pc_x, d_pc_y, d_pa_x, d_pa_y;
  logic signed [DW-1:0] d_cb_x, d_cb_y;

  // Product stage registers.
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, poa_q, pob_q;
  logic [CB-1:0]        x_q, y_q;
  logic                 last_q, start_q, a_v_q;

  logic signed [EW-1:0] e1, e2, e3, eo;
  logic                 swap_q, swap_item, in_tri;
  logic                 en_a, en_b;

  logic                 out_v_q;
  logic [CB-1:0]        out_x_q, out_y_q;
  logic                 out_in_q, out_last_q;

  assign ax = $signed(ax_i);
  assign ay = $signed(ay_i);
  assign bx = $signed(bx_i);
  assign by = $signed(by_i);
  assign cx = $signed(cx_i);
  assign cy = $signed(cy_i);
  assign px = $signed(head_i[CB-1:0]);
  assign py = $signed(head_i[2*CB-1:CB]);
  assign h_last  = head_i[2*CB];
  assign h_start = head_i[2*CB+1];

  // Handshake of the two back stages.
  assign en_b          = !out_v_q || pix_out.ready;
  assign en_a          = !a_v_q || en_b;
  assign pop_o         = head_valid_i && en_a;
  assign stage_valid_o = a_v_q;
  assign stage_en_o    = en_a;

  // Coordinate differences for the edges a-b, b-c, c-a and the orientation.
  always_comb begin
    d_ab_x = DW'(ax) - DW'(bx);
    d_ab_y = DW'(ay) - DW'(by);
    d_bc_x = DW'(bx) - DW'(cx);
    d_bc_y = DW'(by) - DW'(cy);
    d_ca_x = DW'(cx) - DW'(ax);
    d_ca_y = DW'(cy) - DW'(ay);
    d_cb_x = DW'(cx) - DW'(bx);
    d_cb_y = DW'(cy) - DW'(by);
    d_pb_x = DW'(px) - DW'(bx);
    d_pb_y = DW'(py) - DW'(by);
    d_pc_x = DW'(px) - DW'(cx);
    d_pc_y = DW'(py) - DW'(cy);
    d_pa_x = DW'(px) - DW'(ax);
    d_pa_y = DW'(py) - DW'(ay);
  end

  // Product stage: two products per edge function, registered.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p1a_q   <= PW'(d_ab_x) * PW'(d_pb_y);
      p1b_q   <= PW'(d_pb_x) * PW'(d_ab_y);
      p2a_q   <= PW'(d_bc_x) * PW'(d_pc_y);
      p2b_q   <= PW'(d_pc_x) * PW'(d_bc_y);
      p3a_q   <= PW'(d_ca_x) * PW'(d_pa_y);
      p3b_q   <= PW'(d_pa_x) * PW'(d_ca_y);
      poa_q   <= PW'(d_ab_x) * PW'(d_cb_y);
      pob_q   <= PW'(d_cb_x) * PW'(d_ab_y);
      x_q     <= head_i[CB-1:0];
      y_q     <= head_i[2*CB-1:CB];
      last_q  <= h_last;
      start_q <= h_start;
    end
  end

  // Sign stage. A negative triangle flips the sign of every edge function,
  // so the swapped test asks for e1, e2 and e3 all strictly negative.
  always_comb begin
    e1 = EW'(p1a_q) - EW'(p1b_q);
    e2 = EW'(p2a_q) - EW'(p2b_q);
    e3 = EW'(p3a_q) - EW'(p3b_q);
    eo = EW'(poa_q) - EW'(pob_q);
    swap_item = start_q ? (eo < 0) : swap_q;
    if (swap_item) begin
      in_tri = (e1 < 0) && (e2 < 0) && (e3 < 0);
    end else begin
      in_tri = (e1 > 0) && (e2 > 0) && (e3 > 0);
    end
  end

  // Stage valid, the latched orientation and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      swap_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_q <= head_valid_i;
      end
      if (en_b) begin
        out_v_q <= a_v_q;
        if (a_v_q) begin
          swap_q <= swap_item;
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (en_b && a_v_q) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_in_q   <= in_tri;
      out_last_q <= last_q;
    end
  end

  assign pix_out.valid      = out_v_q;
  assign pix_out.pixel_x    = out_x_q;
  assign pix_out.pixel_y    = out_y_q;
  assign pix_out.inside_res = out_in_q;
  assign pix_out.last_point = out_last_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the edge-function triangle scanner with a scan predictor.
`timescale 1ns / 1ps

module tb_top;
  import efts_pkg::*;

  localparam int CB = CoordBitsDef;
  // Indexes past the last vertex register; writes to them must change nothing.
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;
  localparam int RandomItems = 450;
  localparam int ScanCap = 64;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          in_tri;
    logic          last;
  } pixel_t;

  typedef enum logic [1:0] {RowCfg, RowItem, RowFixed} row_kind_e;
  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] idx;
    logic [CB-1:0]         data;
    logic                  restart;
    pixel_t                pix;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CB-1:0]         cfg_data_i;

  efts_in_if item_ch ();
  efts_out_if #(.COORD_BITS(CB)) pix_ch ();

  edge_function_triangle_scan #(.COORD_BITS(CB)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (item_ch),
    .pix_out    (pix_ch)
  );

  // Mirror of the vertex registers and the scan state of the block.
  logic [CB-1:0] vtx_reg [NumCfgRegs] = '{default: '0};
  int            box_xmin = 0;
  int            box_ymin = 0;
  int            box_xmax = 0;
  int            box_ymax = 0;
  int            scan_x = 0;
  int            scan_y = 0;
  logic          orient_swap = 1'b0;
  logic          scan_busy = 1'b0;

  pixel_t        pending_pixels [$];
  idle_mode_e    idle_mode = IdleNone;
  int            rx_hold_left = 0;
  int            items_sent = 0;
  int            mismatch_count = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Twice the signed area of (p, q, r) with q as the pivot.
  function automatic longint edge_fn(int px, int py, int qx, int qy, int rx, int ry);
    return longint'(px - qx) * longint'(ry - qy) - longint'(rx - qx) * longint'(py - qy);
  endfunction

  function automatic int min3(int a, int b, int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int max3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Advances the scan by one item and works out the pixel it reports.
  function automatic pixel_t next_pixel(logic restart);
    int     ax, ay, bx, by, cx, cy, ux, uy, vx, vy;
    pixel_t p;
    ax = int'($signed(vtx_reg[CfgAX]));
    ay = int'($signed(vtx_reg[CfgAY]));
    bx = int'($signed(vtx_reg[CfgBX]));
    by = int'($signed(vtx_reg[CfgBY]));
    cx = int'($signed(vtx_reg[CfgCX]));
    cy = int'($signed(vtx_reg[CfgCY]));
    // A restart, or any item while no scan runs, latches box and orientation.
    if (restart || !scan_busy) begin
      box_xmin = min3(ax, bx, cx);
      box_ymin = min3(ay, by, cy);
      box_xmax = max3(ax, bx, cx);
      box_ymax = max3(ay, by, cy);
      orient_swap = edge_fn(ax, ay, bx, by, cx, cy) < 0;
      scan_x = box_xmin;
      scan_y = box_ymin;
      scan_busy = 1'b1;
    end else if (scan_y < box_ymax) begin
      scan_y++;
    end else begin
      scan_y = box_ymin;
      if (scan_x < box_xmax) scan_x++;
    end
    // A negative orientation swaps the second and third vertex in the edge tests.
    if (orient_swap) begin
      ux = cx; uy = cy; vx = bx; vy = by;
    end else begin
      ux = bx; uy = by; vx = cx; vy = cy;
    end
    p.in_tri = edge_fn(ax, ay, ux, uy, scan_x, scan_y) > 0 &&
               edge_fn(ux, uy, vx, vy, scan_x, scan_y) > 0 &&
               edge_fn(vx, vy, ax, ay, scan_x, scan_y) > 0;
    p.last = scan_x >= box_xmax && scan_y >= box_ymax;
    if (p.last) scan_busy = 1'b0;
    p.x = scan_x[CB-1:0];
    p.y = scan_y[CB-1:0];
    return p;
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IdleSender: return $urandom_range(99) < 49;
      IdleBoth:   return $urandom_range(99) < 31;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(99) < 49;
      IdleBoth:     return $urandom_range(99) < 31;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxBits-1:0] idx, logic [CB-1:0] data);
    stim_row_t r;
    r.kind = RowCfg;
    r.idx = idx;
    r.data = data;
    r.restart = 1'b0;
    r.pix = '0;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic restart);
    stim_row_t r;
    r = cfg_row(CfgAX, '0);
    r.kind = RowItem;
    r.restart = restart;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(logic restart, logic [CB-1:0] x, logic [CB-1:0] y,
                                          logic in_tri, logic last);
    stim_row_t r;
    r = item_row(restart);
    r.kind = RowFixed;
    r.pix = {x, y, in_tri, last};
    return r;
  endfunction

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CB-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx < NumCfgRegs) vtx_reg[idx] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offers one item, waits for its acceptance and records the expected pixel.
  task automatic offer_item(input logic restart, input bit use_fixed, input pixel_t fixed,
                            output pixel_t predicted);
    while (sender_gap()) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.restart <= restart;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    predicted = next_pixel(restart);
    pending_pixels.push_back(use_fixed ? fixed : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every expected pixel has come out.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Loads a random triangle: mostly a few pixels across, sometimes spanning the full range.
  task automatic load_triangle(input bit wide, input bit partial);
    logic [CfgIdxBits-1:0] reg_order [NumCfgRegs];
    int                    base [2];
    int                    spread, i, v, pick;
    reg_order = '{CfgAX, CfgAY, CfgBX, CfgBY, CfgCX, CfgCY};
    spread = $urandom_range(3);
    pick = $urandom_range(NumCfgRegs - 1);
    for (i = 0; i < 2; i++) begin
      case ($urandom_range(7))
        0:       base[i] = -2045;
        1:       base[i] = 2044;
        default: base[i] = int'($urandom_range(4088)) - 2044;
      endcase
    end
    for (i = 0; i < NumCfgRegs; i++) begin
      v = base[i % 2] + int'($urandom_range(2 * spread)) - spread;
      if (wide) v = $urandom;
      if (!partial || i == pick) write_reg(reg_order[i], CB'(v));
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    pix_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        pix_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        pix_ch.ready <= !receiver_stall();
      end
    end
  end

  // Compares every accepted pixel item with the oldest expectation.
  always @(posedge clk_i) begin : pixel_check
    pixel_t got, want;
    if (rst_ni && pix_ch.valid && pix_ch.ready) begin
      got = {pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.inside_res, pix_ch.last_point};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected pixel item: x=%0d y=%0d inside=%0b last=%0b",
                   $signed(got.x), $signed(got.y), got.in_tri, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.in_tri !== want.in_tri ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("pixel mismatch: expected (%0d,%0d,%0b,%0b), got (%0d,%0d,%0b,%0b)",
                     $signed(want.x), $signed(want.y), want.in_tri, want.last,
                     $signed(got.x), $signed(got.y), got.in_tri, got.last);
        end
      end
    end
  end

  // Stimulus: directed table first, then random scans in several idling modes.
  initial begin : stimulus
    stim_row_t rows [$];
    pixel_t    pred;
    int        seg, cnt, base_count, pick, i;
    logic      rbit;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    item_ch.valid = 1'b0;
    item_ch.restart = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // After reset all vertices sit at the origin: a single-point, degenerate box.
    rows.push_back(fixed_row(1'b0, 12'h000, 12'h000, 1'b0, 1'b1));
    rows.push_back(fixed_row(1'b1, 12'h000, 12'h000, 1'b0, 1'b1));
    // Small triangle with two interior pixels; the full 4x3 box is scanned.
    rows.push_back(cfg_row(CfgAX, 12'd0));
    rows.push_back(cfg_row(CfgAY, 12'd0));
    rows.push_back(cfg_row(CfgBX, 12'd3));
    rows.push_back(cfg_row(CfgBY, 12'd1));
    rows.push_back(cfg_row(CfgCX, 12'd1));
    rows.push_back(cfg_row(CfgCY, 12'd2));
    for (i = 0; i < 12; i++) rows.push_back(item_row(1'b0));
    // Vertices at the coordinate extremes; the first column lies on an edge.
    rows.push_back(cfg_row(CfgAX, 12'h800));
    rows.push_back(cfg_row(CfgAY, 12'h800));
    rows.push_back(cfg_row(CfgBX, 12'h7FF));
    rows.push_back(cfg_row(CfgBY, 12'h800));
    rows.push_back(cfg_row(CfgCX, 12'h800));
    rows.push_back(cfg_row(CfgCY, 12'h7FF));
    rows.push_back(fixed_row(1'b1, 12'h800, 12'h800, 1'b0, 1'b0));
    rows.push_back(fixed_row(1'b0, 12'h800, 12'h801, 1'b0, 1'b0));
    rows.push_back(fixed_row(1'b0, 12'h800, 12'h802, 1'b0, 1'b0));
    // Vertices change mid-scan: the latched box stays, the edge tests see the new ones.
    rows.push_back(cfg_row(CfgAX, 12'h7FF));
    rows.push_back(cfg_row(CfgAY, 12'h7FF));
    rows.push_back(cfg_row(CfgBX, 12'h7FF));
    rows.push_back(cfg_row(CfgBY, 12'h7FF));
    rows.push_back(cfg_row(CfgCX, 12'h7FF));
    rows.push_back(cfg_row(CfgCY, 12'h7FF));
    rows.push_back(fixed_row(1'b0, 12'h800, 12'h803, 1'b0, 1'b0));
    rows.push_back(fixed_row(1'b1, 12'h7FF, 12'h7FF, 1'b0, 1'b1));
    // Writes past the last vertex register are ignored.
    rows.push_back(cfg_row(CfgSpareLo, 12'h123));
    rows.push_back(cfg_row(CfgSpareHi, 12'hABC));
    rows.push_back(fixed_row(1'b0, 12'h7FF, 12'h7FF, 1'b0, 1'b1));

    foreach (rows[k]) begin
      case (rows[k].kind)
        RowCfg: begin
          wait_drained();
          write_reg(rows[k].idx, rows[k].data);
        end
        RowItem:  offer_item(rows[k].restart, 1'b0, '0, pred);
        default:  offer_item(rows[k].restart, 1'b1, rows[k].pix, pred);
      endcase
    end

    // Random scans; each begins with the block drained so the vertices can change.
    seg = 0;
    base_count = items_sent;
    while (items_sent < base_count + RandomItems) begin
      wait_drained();
      idle_mode = idle_mode_e'(seg % 4);
      pick = $urandom_range(15);
      if (seg == 5) begin
        // Long receiver hold-off on a wide box so that the block fills and stalls.
        idle_mode = IdleNone;
        load_triangle(1'b1, 1'b0);
        rx_hold_left = 40;
      end else if (pick < 2) begin
        load_triangle(1'b1, 1'b0);
      end else if (pick < 5) begin
        load_triangle(1'b0, 1'b1);
      end else if (pick > 5) begin
        load_triangle(1'b0, 1'b0);
      end
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) == 1) ? CfgSpareHi : CfgSpareLo, CB'($urandom));
      for (cnt = 0; cnt < ScanCap; cnt++) begin
        rbit = (cnt == 0) ? ($urandom_range(1) == 1) : ($urandom_range(99) < 4);
        offer_item(rbit, 1'b0, '0, pred);
        if (pred.last && $urandom_range(3) != 0) break;
      end
      seg++;
    end

    // Drain and let the pipeline settle before the verdict.
    item_ch.valid <= 1'b0;
    idle_mode = IdleNone;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
